>>> src/tlab_pkg.sv
// Shared types, constants and arithmetic helpers for the three-layer alpha blender.
package tlab_pkg;

  localparam int unsigned PIX_W  = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PROD_W = 16;
  localparam int unsigned NUM_CH = 4;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_L1_GALPHA = 2'd0;
  localparam logic [1:0] REG_L2_GALPHA = 2'd1;
  localparam logic [1:0] REG_L3_GALPHA = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_CH-1:0][PROD_W-1:0] sums_t;

  typedef struct packed {
    logic [CHAN_W-1:0] l1;
    logic [CHAN_W-1:0] l2;
    logic [CHAN_W-1:0] l3;
  } galpha_t;

  // floor(x/255), exact for every x up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:CHAN_W]};
    return t[PROD_W-1:CHAN_W];
  endfunction

  // Rebuild a pixel from four channel sums, alpha in the top byte
  function automatic pix_t div_pixel(input sums_t s);
    pix_t p;
    for (int k = 0; k < NUM_CH; k++) begin
      p[k*CHAN_W +: CHAN_W] = div255(s[k]);
    end
    return p;
  endfunction

endpackage

>>> src/tlab_cfg.sv
// Configuration registers for the layer global alphas, on an APB-style port.
module tlab_cfg
  import tlab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output galpha_t     galpha
);

  galpha_t    galpha_r;
  galpha_t    galpha_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = cfg_paddr[3:2];

  always_comb begin
    galpha_nxt = galpha_r;
    if (wr_en) begin
      case (idx)
        REG_L1_GALPHA: galpha_nxt.l1 = cfg_pwdata[CHAN_W-1:0];
        REG_L2_GALPHA: galpha_nxt.l2 = cfg_pwdata[CHAN_W-1:0];
        REG_L3_GALPHA: galpha_nxt.l3 = cfg_pwdata[CHAN_W-1:0];
        default:       galpha_nxt = galpha_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      galpha_r <= '{l1: CHAN_MAX, l2: CHAN_MAX, l3: CHAN_MAX};
    end else begin
      galpha_r <= galpha_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_L1_GALPHA: cfg_prdata = {24'd0, galpha_r.l1};
      REG_L2_GALPHA: cfg_prdata = {24'd0, galpha_r.l2};
      REG_L3_GALPHA: cfg_prdata = {24'd0, galpha_r.l3};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign galpha = galpha_r;

endmodule

>>> src/tlab_mix.sv
// Source-over channel sums F*Fa + B*(255-Fa) for all four channels of a pixel pair.
module tlab_mix
  import tlab_pkg::*;
(
  input  pix_t  back_px,
  input  pix_t  front_px,
  output sums_t sums
);

  logic [CHAN_W-1:0] fa;
  logic [CHAN_W-1:0] fa_inv;

  assign fa     = front_px[PIX_W-1 -: CHAN_W];
  assign fa_inv = CHAN_MAX - fa;

  always_comb begin
    logic [CHAN_W-1:0] f;
    logic [CHAN_W-1:0] b;
    for (int k = 0; k < NUM_CH; k++) begin
      // alpha channel takes the front alpha as its own front value
      f = (k == NUM_CH - 1) ? fa : front_px[k*CHAN_W +: CHAN_W];
      b = back_px[k*CHAN_W +: CHAN_W];
      sums[k] = ({8'd0, f} * {8'd0, fa}) + ({8'd0, b} * {8'd0, fa_inv});
    end
  end

endmodule

>>> src/three_layer_argb_alpha_blend.sv
// Top level of the three-layer ARGB8888 source-over alpha blender.
//
// Usage:
//   in_*   stream channel, one request carries three ARGB8888 pixels:
//          bottom, middle and top layer. out_* carries the composited pixel.
//   cfg_*  APB-style port for the three layer global alphas at 0x0, 0x4, 0x8
//          (low 8 bits used). Write only while the pipeline is empty.
// Each layer's alpha is first scaled by its global alpha, then the middle
// layer is blended over the bottom one and the top layer over that.
// Timing: four register stages (alpha scale product, first blend sums,
// second blend sums, output register). Throughput is one pixel per cycle
// while out_tready is held high, with the divide by 255 of each stage's
// products done in the stage after.
// Stalls: each stage advances when its successor is empty or advancing, so
// a held output lets the upstream stages fill their bubbles before
// in_tready drops. Nothing is lost or repeated.
// Reset: synchronous, active low; empties all stages and sets every global
// alpha to 255.
module three_layer_argb_alpha_blend
  import tlab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tdata: bottom_pixel[31:0], middle_pixel[63:32], top_pixel[95:64]
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: blended_pixel[31:0]
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  galpha_t galpha;

  tlab_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .galpha      (galpha)
  );

  // Stage valid bits and per-stage advance
  logic va_r, vb_r, vc_r, vo_r;
  logic rdy_a, rdy_b, rdy_c, rdy_o;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy_c     = !vc_r || rdy_o;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_tvalid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_o) vo_r <= vc_r;
    end
  end

  // Stage A: alpha times global alpha, hold colour bytes alongside
  logic [PROD_W-1:0] prod1_r, prod2_r, prod3_r;
  logic [23:0]       rgb1_r, rgb2_r, rgb3_r;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod1_r <= {8'd0, in_tdata[31:24]} * {8'd0, galpha.l1};
      prod2_r <= {8'd0, in_tdata[63:56]} * {8'd0, galpha.l2};
      prod3_r <= {8'd0, in_tdata[95:88]} * {8'd0, galpha.l3};
      rgb1_r  <= in_tdata[23:0];
      rgb2_r  <= in_tdata[55:32];
      rgb3_r  <= in_tdata[87:64];
    end
  end

  // Stage B: finish the alpha scale, form middle-over-bottom sums
  pix_t  bottom_px, middle_px;
  sums_t sums_b;
  sums_t sums_b_r;
  pix_t  top_b_r;

  assign bottom_px = {div255(prod1_r), rgb1_r};
  assign middle_px = {div255(prod2_r), rgb2_r};

  tlab_mix u_mix_mid (
    .back_px  (bottom_px),
    .front_px (middle_px),
    .sums     (sums_b)
  );

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      sums_b_r <= sums_b;
      top_b_r  <= {div255(prod3_r), rgb3_r};
    end
  end

  // Stage C: resolve the first blend, form top-over-result sums
  sums_t sums_c;
  sums_t sums_c_r;

  tlab_mix u_mix_top (
    .back_px  (div_pixel(sums_b_r)),
    .front_px (top_b_r),
    .sums     (sums_c)
  );

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      sums_c_r <= sums_c;
    end
  end

  // Output register: resolve the second blend
  pix_t out_px_r;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_px_r <= div_pixel(sums_c_r);
    end
  end

  assign out_tdata  = out_px_r;
  assign out_tvalid = vo_r;

  // A full stage B that cannot advance must keep its sums
  a_hold_b : assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !rdy_c) |=> (vb_r && $stable(sums_b_r) && $stable(top_b_r)))
    else $error("stage B lost its contents under stall");

  // Input is taken only when some stage can make room
  a_room : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!va_r || !vb_r || !vc_r || !vo_r || out_tready))
    else $error("input accepted with a full, stalled pipeline");

  // A stalled output keeps the upstream full stages from moving
  a_back_pressure : assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && vb_r && vc_r && vo_r && !out_tready) |-> !in_tready)
    else $error("full pipeline still accepting");

  // A write to the bottom layer global alpha lands in the next cycle
  a_cfg_l1 : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[3:2] == REG_L1_GALPHA)
      |=> (galpha.l1 == $past(cfg_pwdata[7:0])))
    else $error("layer 1 global alpha write not taken");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the three-layer ARGB8888 alpha blender.
module tb;
  import tlab_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT     = 17;    // chance in a hundred of an idle cycle
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int unsigned PIPE_LAT     = 4;     // acceptance to out_tvalid
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned NUM_DIRECTED = 12;
  localparam int unsigned ALPHA_LSB    = 24;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;  // decoded by nothing; writes must be ignored

  // One row of the directed table; result is only used when known is set
  typedef struct packed {
    pix_t bottom;
    pix_t middle;
    pix_t top;
    logic known;
    pix_t result;
  } blend_case_t;

  logic        clk;
  logic        rst_n;
  logic [95:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Expected composited pixels, oldest first
  pix_t        pending_pixels[$];
  galpha_t     layer_galpha;      // shadow of the three global alpha registers
  logic        typed_known;       // current request carries a hand-written result
  pix_t        typed_result;
  pix_t        want_px;
  bit          idle_on;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  three_layer_argb_alpha_blend uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Compositing predictor
  // ---------------------------------------------------------------------------

  // floor(a*g/255) for the pixel's own alpha, colour bytes untouched
  function automatic pix_t scale_layer(pix_t px, logic [CHAN_W-1:0] g);
    int unsigned a;
    a = int'(px[ALPHA_LSB +: CHAN_W]) * int'(g) / int'(CHAN_MAX);
    px[ALPHA_LSB +: CHAN_W] = a[CHAN_W-1:0];
    return px;
  endfunction

  // floor((f*fa + b*(255-fa))/255); never exceeds 255
  function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] f,
                                                    logic [CHAN_W-1:0] b,
                                                    logic [CHAN_W-1:0] fa);
    int unsigned s;
    s = (int'(f) * int'(fa) + int'(b) * (int'(CHAN_MAX) - int'(fa))) / int'(CHAN_MAX);
    return s[CHAN_W-1:0];
  endfunction

  // Source-over of front on back; alpha uses the front alpha as its own front value
  function automatic pix_t blend_layers(pix_t back, pix_t front);
    logic [CHAN_W-1:0] fa;
    pix_t              res;
    fa = front[ALPHA_LSB +: CHAN_W];
    for (int k = 0; k < NUM_CH - 1; k++) begin
      res[k*CHAN_W +: CHAN_W] = mix_channel(front[k*CHAN_W +: CHAN_W],
                                            back[k*CHAN_W +: CHAN_W], fa);
    end
    res[ALPHA_LSB +: CHAN_W] = mix_channel(fa, back[ALPHA_LSB +: CHAN_W], fa);
    return res;
  endfunction

  function automatic pix_t composite_pixel(pix_t bottom, pix_t middle, pix_t top,
                                           galpha_t g);
    return blend_layers(blend_layers(scale_layer(bottom, g.l1), scale_layer(middle, g.l2)),
                        scale_layer(top, g.l3));
  endfunction

  // Alpha leans on the corner values 0 and 255; colour bytes are mostly random
  function automatic pix_t random_argb();
    pix_t px;
    px = $urandom;
    case ($urandom_range(3))
      0: px[ALPHA_LSB +: CHAN_W] = '0;
      1: px[ALPHA_LSB +: CHAN_W] = CHAN_MAX;
      default: ;
    endcase
    if ($urandom_range(15) == 0) begin
      px[ALPHA_LSB-1:0] = $urandom_range(1) ? '1 : '0;
    end
    return px;
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want_px = typed_known ? typed_result
                              : composite_pixel(in_tdata[31:0], in_tdata[63:32],
                                                in_tdata[95:64], layer_galpha);
        pending_pixels.push_back(want_px);
      end
      if (out_tvalid && out_tready) begin
        pixels_checked++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch("blended pixel with nothing outstanding", '0, out_tdata);
        end else begin
          want_px = pending_pixels.pop_front();
          if (out_tdata !== want_px) begin
            flag_mismatch("blended_pixel", want_px, out_tdata);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel completes a handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall at random while idling is allowed
  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request, with random idle cycles ahead of it; return once accepted
  task automatic send_pixel(pix_t bottom, pix_t middle, pix_t top,
                            logic known, pix_t result);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata     <= {top, middle, bottom};
    in_tvalid    <= 1'b1;
    typed_known  <= known;
    typed_result <= result;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pixels_sent++;
  endtask

  // Drop valid and hold until every outstanding result has been checked
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // only the low byte is kept; the unused slot swallows the write
    case (idx)
      REG_L1_GALPHA: layer_galpha.l1 = data[CHAN_W-1:0];
      REG_L2_GALPHA: layer_galpha.l2 = data[CHAN_W-1:0];
      REG_L3_GALPHA: layer_galpha.l3 = data[CHAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_check(logic [1:0] idx, logic [CHAN_W-1:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'h0, want}) begin
      flag_mismatch("global alpha readback", {24'h0, want}, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_all_galpha();
    cfg_check(REG_L1_GALPHA, layer_galpha.l1);
    cfg_check(REG_L2_GALPHA, layer_galpha.l2);
    cfg_check(REG_L3_GALPHA, layer_galpha.l3);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run with every global alpha at its reset value of 255.
  // Opaque fronts pass straight through, transparent fronts leave the back
  // untouched; partial alphas go to the predictor.
  // ---------------------------------------------------------------------------
  blend_case_t directed_cases [NUM_DIRECTED] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    // both fronts fully transparent: bottom comes through as is
    '{32'h80ABCDEF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h80ABCDEF},
    '{32'h00FFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'h00FFFFFF},
    // opaque middle under a transparent top
    '{32'h12345678, 32'hFF9A8B7C, 32'h00000000, 1'b1, 32'hFF9A8B7C},
    // opaque top hides everything
    '{32'hFFFFFFFF, 32'h80FFFFFF, 32'hFF010203, 1'b1, 32'hFF010203},
    '{32'hFF000000, 32'h80FFFFFF, 32'h00000000, 1'b0, 32'h0},
    '{32'hFF102030, 32'h00000000, 32'h80FF00FF, 1'b0, 32'h0},
    '{32'h00FFFFFF, 32'h7F808080, 32'h01FFFFFF, 1'b0, 32'h0},
    '{32'hFEFFFFFF, 32'hFE000000, 32'hFEFFFFFF, 1'b0, 32'h0},
    '{32'h01010101, 32'h7F7F7F7F, 32'h80808080, 1'b0, 32'h0},
    '{32'hA5A5A5A5, 32'h5A5A5A5A, 32'hC33CC33C, 1'b0, 32'h0}
  };

  // Global alpha settings per phase: extremes first, then mixed, then random
  galpha_t fixed_settings [4] = '{
    '{8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'h80},
    '{8'h01, 8'hFE, 8'h7F}
  };

  initial begin
    galpha_t g;
    rst_n          = 1'b0;
    in_tdata       = '0;
    in_tvalid      = 1'b0;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    typed_known    = 1'b0;
    typed_result   = '0;
    idle_on        = 1'b1;
    mismatches     = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    settings_used  = 1;
    quiet_cycles   = 0;
    layer_galpha   = '{CHAN_MAX, CHAN_MAX, CHAN_MAX};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every register should read back 255 out of reset
    check_all_galpha();

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_pixel(directed_cases[i].bottom, directed_cases[i].middle, directed_cases[i].top,
                 directed_cases[i].known, directed_cases[i].result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // hold off the sender until the pipeline is empty before touching registers
      drain_pipeline();
      if (p < 4) begin
        g = fixed_settings[p];
      end else begin
        g = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
      end
      // random upper bits must be dropped by the register
      cfg_write(REG_L1_GALPHA, {24'($urandom_range(32'hFFFFFF)), g.l1});
      cfg_write(REG_L2_GALPHA, {24'($urandom_range(32'hFFFFFF)), g.l2});
      cfg_write(REG_L3_GALPHA, {24'($urandom_range(32'hFFFFFF)), g.l3});
      if (p == 3) begin
        cfg_write(REG_UNUSED, $urandom);
      end
      check_all_galpha();
      settings_used++;

      // one long stretch with neither side idling
      idle_on = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(random_argb(), random_argb(), random_argb(), 1'b0, '0);
      end
      idle_on = 1'b1;
    end

    drain_pipeline();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      flag_mismatch("results never delivered", pending_pixels.size(), 0);
    end

    $display("Blended %0d pixel triples under %0d global alpha settings, %0d results checked",
             pixels_sent, settings_used, pixels_checked);
    $display("Covered opaque, transparent and partial layers, register readback, %0d mismatch(es)",
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/tlab_pkg.sv
src/tlab_cfg.sv
src/tlab_mix.sv
src/three_layer_argb_alpha_blend.sv
tb/tb.sv
